### rtl/isfrl_pkg.sv
// package for the ipv4 source filter and rate limiter
// types, constants and helpers for all rtl files but the fifo
package isfrl_pkg;

    localparam int BLOCK_ENTRIES_DEF = 16;
    localparam int RATE_ENTRIES_DEF  = 16;
    localparam int SLOT_W            = 4;
    localparam int CFG_IDX_W         = 1;
    localparam int CFG_DATA_W        = 40;

    localparam logic [39:0] WINDOW_RESET = 40'd1000000000;
    localparam logic [15:0] AMP_RESET    = 16'd512;
    localparam logic [31:0] PKT_SAT      = 32'hFFFF_FFFF;
    localparam logic [47:0] BYTE_SAT     = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        MODE_PACKET = 2'd0,
        MODE_BLOCK  = 2'd1,
        MODE_RATE   = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CAUSE_NONE  = 2'd0,
        CAUSE_BLOCK = 2'd1,
        CAUSE_RATE  = 2'd2,
        CAUSE_AMP   = 2'd3
    } cause_t;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP    = 1'd1;

    typedef struct packed {
        logic [1:0]        mode;
        logic [SLOT_W-1:0] slot;
        logic              entry_valid;
        logic [31:0]       address;
        logic [5:0]        prefix_len;
        logic [31:0]       pkt_limit;
        logic [31:0]       byte_limit;
        logic [63:0]       timestamp_ns;
        logic [15:0]       pkt_len;
        logic              is_ipv4;
        logic              is_udp;
        logic [15:0]       source_port;
    } in_item_t;

    typedef struct packed {
        logic       drop;
        logic [1:0] drop_cause;
    } out_item_t;

    // classified item handed from front to back
    typedef struct packed {
        logic        is_rate_wr;
        logic        rate_wr_valid;
        logic        do_rate;
        logic [31:0] pkt_limit;
        logic [31:0] byte_limit;
        logic [63:0] timestamp_ns;
        logic [15:0] pkt_len;
        logic        blocked;
        logic        amp_hit;
        logic        check;
    } job_t;

    function automatic logic [31:0] prefix_mask(input logic [5:0] len);
        logic [31:0] m;
        m = '0;
        for (int i = 0; i < 32; i++) begin
            m[31-i] = (len > 6'(i));
        end
        return m;
    endfunction

    function automatic logic amp_port(input logic [15:0] p);
        return p == 16'd19 || p == 16'd53 || p == 16'd123 || p == 16'd161 ||
               p == 16'd389 || p == 16'd1900 || p == 16'd11211;
    endfunction

endpackage

### rtl/isfrl_front.sv
// front part: blocklist table, rate entry address lookup, classification
// depends on isfrl_pkg
module isfrl_front #(
    parameter int BLOCK_ENTRIES = isfrl_pkg::BLOCK_ENTRIES_DEF,
    parameter int RATE_ENTRIES  = isfrl_pkg::RATE_ENTRIES_DEF,
    parameter int RIDX_W        = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_fire,
    input  isfrl_pkg::in_item_t  in_item,
    input  logic [15:0]          amp_len,
    output isfrl_pkg::job_t      job,
    output logic [RIDX_W-1:0]    job_idx
);
    import isfrl_pkg::*;

    logic [BLOCK_ENTRIES-1:0] bvalid_reg;
    logic [31:0]              baddr_reg [BLOCK_ENTRIES];
    logic [5:0]               bpref_reg [BLOCK_ENTRIES];
    logic [RATE_ENTRIES-1:0]  rvalid_reg;
    logic [31:0]              raddr_reg [RATE_ENTRIES];
    logic [BLOCK_ENTRIES-1:0] bhit;
    logic [RATE_ENTRIES-1:0]  rhit;
    logic                     rfound;
    logic [RIDX_W-1:0]        rsel;
    logic [5:0]               plen_sat;

    assign plen_sat = (in_item.prefix_len > 6'd32) ? 6'd32 : in_item.prefix_len;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bvalid_reg <= '0;
            rvalid_reg <= '0;
        end else if (in_fire) begin
            if (in_item.mode == MODE_BLOCK && 32'(in_item.slot) < BLOCK_ENTRIES) begin
                bvalid_reg[in_item.slot] <= in_item.entry_valid;
            end
            if (in_item.mode == MODE_RATE && 32'(in_item.slot) < RATE_ENTRIES) begin
                rvalid_reg[in_item.slot] <= in_item.entry_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < BLOCK_ENTRIES; i++) begin
            if (in_fire && in_item.mode == MODE_BLOCK && 32'(in_item.slot) == i) begin
                baddr_reg[i] <= in_item.address;
                bpref_reg[i] <= plen_sat;
            end
        end
        for (int i = 0; i < RATE_ENTRIES; i++) begin
            if (in_fire && in_item.mode == MODE_RATE && 32'(in_item.slot) == i) begin
                raddr_reg[i] <= in_item.address;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < BLOCK_ENTRIES; i++) begin
            bhit[i] = bvalid_reg[i] &&
                      (((in_item.address ^ baddr_reg[i]) & prefix_mask(bpref_reg[i])) == '0);
        end
        for (int i = 0; i < RATE_ENTRIES; i++) begin
            rhit[i] = rvalid_reg[i] && raddr_reg[i] == in_item.address;
        end
        rfound = |rhit;
        rsel   = '0;
        for (int i = RATE_ENTRIES - 1; i >= 0; i--) begin
            if (rhit[i]) begin
                rsel = RIDX_W'(i);
            end
        end
    end

    always_comb begin
        job               = '0;
        job.pkt_limit     = in_item.pkt_limit;
        job.byte_limit    = in_item.byte_limit;
        job.timestamp_ns  = in_item.timestamp_ns;
        job.pkt_len       = in_item.pkt_len;
        job.rate_wr_valid = in_item.entry_valid;
        job.is_rate_wr    = in_item.mode == MODE_RATE && 32'(in_item.slot) < RATE_ENTRIES;
        job.check         = in_item.mode == MODE_PACKET && in_item.is_ipv4;
        job.blocked       = |bhit;
        job.do_rate       = job.check && !job.blocked && rfound;
        job.amp_hit       = in_item.is_udp && amp_port(in_item.source_port) &&
                            in_item.pkt_len > amp_len;
        job_idx           = job.is_rate_wr ? RIDX_W'(in_item.slot) : rsel;
    end

endmodule

### rtl/isfrl_fifo.sv
// short queue between front and back parts
// depends on no other file
module isfrl_fifo #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         wr_en,
    input  logic [W-1:0] wr_data,
    output logic         full,
    input  logic         rd_en,
    output logic [W-1:0] rd_data,
    output logic         empty
);
    logic [W-1:0] mem_reg [2];
    logic         wp_reg, rp_reg;
    logic [1:0]   cnt_reg;

    assign full    = cnt_reg == 2'd2;
    assign empty   = cnt_reg == 2'd0;
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr_en) wp_reg <= ~wp_reg;
            if (rd_en) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(wr_en) - 2'(rd_en);
        end
    end

endmodule

### rtl/isfrl_back.sv
// back part: per-source window state, limit checks, verdict register
// depends on isfrl_pkg
module isfrl_back #(
    parameter int RATE_ENTRIES = isfrl_pkg::RATE_ENTRIES_DEF,
    parameter int RIDX_W       = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  job_valid,
    input  isfrl_pkg::job_t       job,
    input  logic [RIDX_W-1:0]     job_idx,
    output logic                  job_take,
    input  logic [39:0]           window_len,
    output logic                  m_valid,
    input  logic                  m_ready,
    output isfrl_pkg::out_item_t  m_item
);
    import isfrl_pkg::*;

    logic [RATE_ENTRIES-1:0] started_reg;
    logic [31:0]             pps_reg   [RATE_ENTRIES];
    logic [31:0]             bps_reg   [RATE_ENTRIES];
    logic [31:0]             pkts_reg  [RATE_ENTRIES];
    logic [47:0]             bytes_reg [RATE_ENTRIES];
    logic [63:0]             tstart_reg[RATE_ENTRIES];
    logic                    ov_reg;
    out_item_t               out_reg, out_next;
    logic                    restart, over;
    logic [63:0]             elapsed;
    logic [48:0]             bsum;
    logic [31:0]             s_pkts, s_pps, s_bps;
    logic [47:0]             s_bytes;

    assign job_take = job_valid && (!ov_reg || m_ready);
    assign m_valid  = ov_reg;
    assign m_item   = out_reg;

    always_comb begin
        s_pkts  = pkts_reg[job_idx];
        s_bytes = bytes_reg[job_idx];
        s_pps   = pps_reg[job_idx];
        s_bps   = bps_reg[job_idx];
        elapsed = job.timestamp_ns - tstart_reg[job_idx];
        restart = !started_reg[job_idx] || elapsed >= 64'(window_len);
        over    = (s_pps != '0 && s_pkts >= s_pps) ||
                  (s_bps != '0 && s_bytes >= 48'(s_bps));
        bsum    = 49'(s_bytes) + 49'(job.pkt_len);
        out_next = '0;
        if (job.check) begin
            if (job.blocked) begin
                out_next.drop_cause = CAUSE_BLOCK;
            end else if (job.do_rate && !restart && over) begin
                out_next.drop_cause = CAUSE_RATE;
            end else if (job.amp_hit) begin
                out_next.drop_cause = CAUSE_AMP;
            end
        end
        out_next.drop = out_next.drop_cause != CAUSE_NONE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg      <= 1'b0;
            started_reg <= '0;
        end else begin
            if (job_take) begin
                ov_reg <= 1'b1;
            end else if (m_ready) begin
                ov_reg <= 1'b0;
            end
            if (job_take && job.is_rate_wr) begin
                started_reg[job_idx] <= 1'b0;
            end else if (job_take && job.do_rate && restart) begin
                started_reg[job_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (job_take) begin
            out_reg <= out_next;
            if (job.is_rate_wr) begin
                pps_reg[job_idx] <= job.pkt_limit;
                bps_reg[job_idx] <= job.byte_limit;
            end else if (job.do_rate) begin
                if (restart) begin
                    pkts_reg[job_idx]   <= 32'd1;
                    bytes_reg[job_idx]  <= 48'(job.pkt_len);
                    tstart_reg[job_idx] <= job.timestamp_ns;
                end else if (!over) begin
                    pkts_reg[job_idx]  <= (s_pkts == PKT_SAT) ? s_pkts : s_pkts + 32'd1;
                    bytes_reg[job_idx] <= bsum[48] ? BYTE_SAT : bsum[47:0];
                end
            end
        end
    end

endmodule

### rtl/ipv4_source_filter_rate_limiter.sv
// top level of the ipv4 source filter and rate limiter
// depends on isfrl_pkg, isfrl_front, isfrl_fifo, isfrl_back
//
// Each item passes the front (blocklist prefix compare and rate entry address
// match, all entries in parallel), is registered in a two-entry queue, then
// passes the back (window read, limit check, counter update) into the verdict
// register. The back serializes on the window state, so the sustained rate is
// one item every cycle while the result side keeps m_ready high.
// Results appear in input order, one per item. No clearing pass after reset.
module ipv4_source_filter_rate_limiter #(
    parameter int BLOCK_ENTRIES = isfrl_pkg::BLOCK_ENTRIES_DEF,
    parameter int RATE_ENTRIES  = isfrl_pkg::RATE_ENTRIES_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  isfrl_pkg::in_item_t                   s_item,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output isfrl_pkg::out_item_t                  m_item,
    input  logic                                  cfg_we,
    input  logic [isfrl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [isfrl_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import isfrl_pkg::*;

    localparam int RIDX_W = (RATE_ENTRIES > 1) ? $clog2(RATE_ENTRIES) : 1;
    localparam int QW     = $bits(job_t) + RIDX_W;

    logic [39:0]       window_len_reg;
    logic [15:0]       amp_len_reg;
    logic              q_full, q_empty, q_take, in_fire;
    job_t              f_job, b_job;
    logic [RIDX_W-1:0] f_idx, b_idx;

    assign s_ready = !q_full;
    assign in_fire = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_len_reg <= WINDOW_RESET;
            amp_len_reg    <= AMP_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_WINDOW: window_len_reg <= cfg_data[39:0];
                CFG_AMP:    amp_len_reg    <= cfg_data[15:0];
                default:    ;
            endcase
        end
    end

    isfrl_front #(
        .BLOCK_ENTRIES(BLOCK_ENTRIES),
        .RATE_ENTRIES (RATE_ENTRIES),
        .RIDX_W       (RIDX_W)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .in_item (s_item),
        .amp_len (amp_len_reg),
        .job     (f_job),
        .job_idx (f_idx)
    );

    isfrl_fifo #(.W(QW)) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (in_fire),
        .wr_data ({f_job, f_idx}),
        .full    (q_full),
        .rd_en   (q_take),
        .rd_data ({b_job, b_idx}),
        .empty   (q_empty)
    );

    isfrl_back #(
        .RATE_ENTRIES(RATE_ENTRIES),
        .RIDX_W      (RIDX_W)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .job_valid  (!q_empty),
        .job        (b_job),
        .job_idx    (b_idx),
        .job_take   (q_take),
        .window_len (window_len_reg),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );

endmodule

### rtl/isfrl_checker.sv
// port-level checker for the ipv4 source filter and rate limiter
// depends on isfrl_pkg; bound to the top level
module isfrl_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input isfrl_pkg::out_item_t m_item,
    input logic                 m_valid,
    input logic                 m_ready
);
    import isfrl_pkg::*;

    a_drop_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.drop == (m_item.drop_cause != CAUSE_NONE)))
        else $error("drop disagrees with cause");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |-> ##2 m_valid)
        else $error("accepted word gave no result");

endmodule

bind ipv4_source_filter_rate_limiter isfrl_checker u_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_item  (m_item),
    .m_valid (m_valid),
    .m_ready (m_ready)
);

### dv/tb.sv
// testbench for ipv4_source_filter_rate_limiter: drives packet and table write
// words, predicts verdicts with a local model, checks results in order
// depends on isfrl_pkg and the rtl of ipv4_source_filter_rate_limiter
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import isfrl_pkg::*;

    class verdict_scoreboard;
        logic [39:0] win_len;
        logic [15:0] amp_len;
        logic        blk_v[16];
        logic [31:0] blk_a[16];
        logic [5:0]  blk_p[16];
        logic        rt_v[16];
        logic [31:0] rt_a[16];
        logic [31:0] rt_pps[16];
        logic [31:0] rt_bps[16];
        logic        w_on[16];
        logic [31:0] w_pkts[16];
        logic [47:0] w_bytes[16];
        logic [63:0] w_t0[16];
        out_item_t   pending_verdicts[$];
        int          errors;

        function new();
            win_len = WINDOW_RESET;
            amp_len = AMP_RESET;
            errors = 0;
            for (int i = 0; i < 16; i++) begin
                blk_v[i] = 0; rt_v[i] = 0; w_on[i] = 0;
            end
        endfunction

        function void set_reg(logic idx, logic [39:0] d);
            if (idx == CFG_WINDOW) win_len = d;
            else amp_len = d[15:0];
        endfunction

        function logic rate_hit(logic [31:0] src, logic [63:0] now, logic [15:0] len);
            int s;
            logic [48:0] sum;
            s = -1;
            for (int i = 15; i >= 0; i--)
                if (rt_v[i] && rt_a[i] == src) s = i;
            if (s < 0) return 0;
            if (!w_on[s] || (now - w_t0[s]) >= {24'd0, win_len}) begin
                w_on[s] = 1; w_pkts[s] = 1; w_bytes[s] = 48'(len); w_t0[s] = now;
                return 0;
            end
            if (rt_pps[s] != 0 && w_pkts[s] >= rt_pps[s]) return 1;
            if (rt_bps[s] != 0 && w_bytes[s] >= {16'd0, rt_bps[s]}) return 1;
            if (w_pkts[s] != PKT_SAT) w_pkts[s]++;
            sum = 49'(w_bytes[s]) + 49'(len);
            w_bytes[s] = sum[48] ? BYTE_SAT : sum[47:0];
            return 0;
        endfunction

        function void note_word(in_item_t it);
            cause_t c;
            logic [31:0] m;
            logic [5:0] p;
            c = CAUSE_NONE;
            if (it.mode == MODE_BLOCK) begin
                blk_v[it.slot] = it.entry_valid;
                blk_a[it.slot] = it.address;
                blk_p[it.slot] = it.prefix_len > 32 ? 6'd32 : it.prefix_len;
            end else if (it.mode == MODE_RATE) begin
                rt_v[it.slot] = it.entry_valid;
                rt_a[it.slot] = it.address;
                rt_pps[it.slot] = it.pkt_limit;
                rt_bps[it.slot] = it.byte_limit;
                w_on[it.slot] = 0;
            end else if (it.mode == MODE_PACKET && it.is_ipv4) begin
                for (int i = 0; i < 16; i++)
                    if (blk_v[i] && c == CAUSE_NONE) begin
                        p = blk_p[i];
                        m = (p == 0) ? 32'd0 : 32'hFFFF_FFFF << (32 - p);
                        if (((it.address ^ blk_a[i]) & m) == 0) c = CAUSE_BLOCK;
                    end
                if (c == CAUSE_NONE) begin
                    if (rate_hit(it.address, it.timestamp_ns, it.pkt_len)) c = CAUSE_RATE;
                    else if (it.is_udp && (it.source_port == 19 || it.source_port == 53
                             || it.source_port == 123 || it.source_port == 161
                             || it.source_port == 389 || it.source_port == 1900
                             || it.source_port == 11211) && it.pkt_len > amp_len)
                        c = CAUSE_AMP;
                end
            end
            pending_verdicts.push_back('{drop: c != CAUSE_NONE, drop_cause: c});
        endfunction

        function void check_word(out_item_t got);
            out_item_t exp;
            if (pending_verdicts.size() == 0) begin
                $error("unexpected result word %p", got);
                errors++;
                return;
            end
            exp = pending_verdicts.pop_front();
            if (got.drop !== exp.drop) begin
                $error("drop: expected %0d actual %0d", exp.drop, got.drop);
                errors++;
            end
            if (got.drop_cause !== exp.drop_cause) begin
                $error("drop_cause: expected %0d actual %0d", exp.drop_cause, got.drop_cause);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    in_item_t s_item = '0;
    logic m_valid;
    logic m_ready = 0;
    out_item_t m_item;
    logic cfg_we = 0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    verdict_scoreboard sb = new();

    logic [31:0] src_pool[8];
    logic [15:0] amp_ports[7] = '{19, 53, 123, 161, 389, 1900, 11211};
    logic [63:0] clock_ns = 0;

    ipv4_source_filter_rate_limiter i_dut (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_word(m_item);
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_word(in_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_item <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_word(it);
    endtask

    task automatic write_reg(logic idx, logic [39:0] d);
        s_valid <= 0;
        while (sb.pending_verdicts.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge aclk);
        cfg_we <= 0;
        sb.set_reg(idx, d);
    endtask

    function automatic in_item_t rand_word();
        in_item_t it;
        logic [223:0] raw;
        int r;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(in_item_t)-1:0];
        r = $urandom_range(99);
        if (r < 75) begin
            it.mode = MODE_PACKET;
            it.is_ipv4 = ($urandom_range(9) != 0);
            it.address = ($urandom_range(3) != 0) ? src_pool[$urandom_range(7)] : $urandom;
            clock_ns += ($urandom_range(3) == 0) ? {$urandom, $urandom}
                                                 : 64'($urandom_range(200));
            it.timestamp_ns = clock_ns;
            if ($urandom_range(1)) it.pkt_len = 16'($urandom_range(1500));
            if ($urandom_range(1)) it.source_port = amp_ports[$urandom_range(6)];
        end else if (r < 83) begin
            it.mode = MODE_BLOCK;
            it.address = src_pool[$urandom_range(7)];
            it.prefix_len = ($urandom_range(2) == 0) ? 6'($urandom) : 6'($urandom_range(32, 24));
            it.entry_valid = ($urandom_range(3) != 0);
        end else if (r < 97) begin
            it.mode = MODE_RATE;
            it.address = src_pool[$urandom_range(7)];
            it.entry_valid = ($urandom_range(4) != 0);
            if ($urandom_range(3) != 0) it.pkt_limit = $urandom_range(8);
            if ($urandom_range(3) != 0) it.byte_limit = $urandom_range(6000);
        end else begin
            it.mode = MODE_UNUSED;
        end
        return it;
    endfunction

    function automatic in_item_t pkt(logic [31:0] a, logic [63:0] t, logic [15:0] l,
                                     logic v4, logic udp, logic [15:0] port);
        in_item_t it;
        it = '0;
        it.mode = MODE_PACKET; it.address = a; it.timestamp_ns = t; it.pkt_len = l;
        it.is_ipv4 = v4; it.is_udp = udp; it.source_port = port;
        return it;
    endfunction

    function automatic in_item_t entry(mode_t md, logic [3:0] sl, logic v, logic [31:0] a,
                                       logic [5:0] pl, logic [31:0] plim, logic [31:0] blim);
        in_item_t it;
        it = '0;
        it.mode = md; it.slot = sl; it.entry_valid = v; it.address = a;
        it.prefix_len = pl; it.pkt_limit = plim; it.byte_limit = blim;
        return it;
    endfunction

    initial begin
        #50ms;
        $display("ipv4_source_filter_rate_limiter: mismatch");
        $finish;
    end

    initial begin
        logic [39:0] wins[4] = '{40'd1, 40'd500, 40'hFF_FFFF_FFFF, 40'd0};
        logic [15:0] amps[4] = '{16'd0, 16'd1000, 16'hFFFF, 16'd100};
        for (int i = 0; i < 8; i++) src_pool[i] = $urandom;
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        send_word(pkt(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1, 1, 16'd53));
        send_word(pkt(32'h0, 0, 16'd600, 0, 1, 16'd53));
        send_word(entry(MODE_BLOCK, 4'd15, 1, 32'h0A00_0000, 6'd8, 0, 0));
        send_word(pkt(32'h0A12_3456, 5, 16'd64, 1, 0, 0));
        send_word(entry(MODE_BLOCK, 4'd0, 1, 32'hC0A8_0101, 6'd63, 0, 0));
        send_word(pkt(32'hC0A8_0101, 6, 16'd64, 1, 0, 0));
        send_word(pkt(32'hC0A8_0102, 7, 16'd64, 1, 0, 0));
        send_word(entry(MODE_RATE, 4'd3, 1, 32'h0101_0101, 0, 32'd2, 32'd0));
        send_word(entry(MODE_RATE, 4'd1, 1, 32'h0101_0101, 0, 32'd0, 32'd100));
        for (int i = 0; i < 4; i++)
            send_word(pkt(32'h0101_0101, 64'hFFFF_FFFF_FFFF_FFF0 + i, 16'd60, 1, 1, 16'd19));
        send_word(entry(MODE_RATE, 4'd1, 0, 32'h0101_0101, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_word(pkt(32'h0101_0101, 64'h20, 16'd700, 1, 1, 16'd11211));
        send_word(pkt(32'h0202_0202, 64'h20, 16'd513, 1, 1, 16'd1900));
        send_word(entry(MODE_UNUSED, 4'd2, 1, 32'h0202_0202, 6'd0, 0, 0));
        send_word(entry(MODE_BLOCK, 4'd15, 1, 32'h0, 6'd0, 0, 0));
        send_word(pkt(32'h0303_0303, 64'h30, 16'd64, 1, 0, 0));
        send_word(entry(MODE_BLOCK, 4'd15, 0, 32'h0, 6'd0, 0, 0));
        send_word(entry(MODE_BLOCK, 4'd0, 0, 32'h0, 6'd0, 0, 0));
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_WINDOW, wins[ph]);
            write_reg(CFG_AMP, {24'd0, amps[ph]});
            send_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 51 : 0;
            recv_idle_pct = (ph == 0) ? 51 : (ph == 1) ? 18 : 0;
            for (int n = 0; n < 400; n++) send_word(rand_word());
        end
        s_valid <= 0;
        while (sb.pending_verdicts.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.errors == 0) $display("ipv4_source_filter_rate_limiter: match");
        else $display("ipv4_source_filter_rate_limiter: mismatch");
        $finish;
    end
endmodule

### sim.f
rtl/isfrl_pkg.sv
rtl/isfrl_front.sv
rtl/isfrl_fifo.sv
rtl/isfrl_back.sv
rtl/ipv4_source_filter_rate_limiter.sv
rtl/isfrl_checker.sv
dv/tb.sv
